// ===== rtl/fbs_pkg.sv =====
// shared types and constants of the feedback effect sequencer
// no dependencies; used by fbs_front, fbs_queue, fbs_back and the top level
`timescale 1ns / 1ps

package fbs_pkg;

    // command codes
    localparam logic CMD_START = 1'b0;
    localparam logic CMD_TICK  = 1'b1;

    // intensity limits
    localparam logic [3:0] LEVEL_MIN = 4'd1;
    localparam logic [3:0] LEVEL_MAX = 4'd5;

    // run length pieces in ms
    localparam logic [11:0] DUR_STEP_MS   = 12'd400;
    localparam logic [11:0] DUR_GENTLE_MS = 12'd400;
    localparam logic [11:0] DUR_BRISK_MS  = 12'd200;

    // led toggle intervals in ms
    localparam logic [7:0] IVL_GENTLE_MS = 8'd180;
    localparam logic [7:0] IVL_BRISK_MS  = 8'd90;

    // buzzer tones in hz
    localparam logic [10:0] TONE_GENTLE_START = 11'd880;
    localparam logic [10:0] TONE_BRISK_START  = 11'd1400;
    localparam logic [10:0] TONE_GENTLE_HI    = 11'd988;
    localparam logic [10:0] TONE_GENTLE_LO    = 11'd784;
    localparam logic [10:0] TONE_BRISK_HI     = 11'd1568;
    localparam logic [10:0] TONE_BRISK_LO     = 11'd1319;
    localparam logic [10:0] TONE_OFF          = 11'd0;

    // queue between front and back
    localparam int QUEUE_DEPTH = 2;
    localparam int QUEUE_PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int QUEUE_CNT_W = $clog2(QUEUE_DEPTH + 1);

    // classified item, without its time stamp
    typedef struct packed {
        logic        is_tick;
        logic        gentle;
        logic [11:0] run_len;
    } op_t;

endpackage

// ===== rtl/fbs_front.sv =====
// front end: classifies an incoming item and works out the start parameters
// depends on fbs_pkg
`timescale 1ns / 1ps

module fbs_front
(
    input  logic             cmd,
    input  logic             gentle,
    input  logic [3:0]       intensity,
    output fbs_pkg::op_t     op
);

    logic [3:0]  level_sat;
    logic [11:0] base_len;

    always_comb
    begin
        // saturate to 1..5
        if (intensity < fbs_pkg::LEVEL_MIN)
        begin
            level_sat = fbs_pkg::LEVEL_MIN;
        end
        else if (intensity > fbs_pkg::LEVEL_MAX)
        begin
            level_sat = fbs_pkg::LEVEL_MAX;
        end
        else
        begin
            level_sat = intensity;
        end
    end

    assign base_len = 12'({8'd0, level_sat} * fbs_pkg::DUR_STEP_MS);

    always_comb
    begin
        op.is_tick = (cmd == fbs_pkg::CMD_TICK);
        op.gentle  = gentle;
        op.run_len = base_len + (gentle ? fbs_pkg::DUR_GENTLE_MS : fbs_pkg::DUR_BRISK_MS);
    end

endmodule

// ===== rtl/fbs_queue.sv =====
// short fifo that decouples the front end from the back end
// depends on fbs_pkg for depth and pointer widths
`timescale 1ns / 1ps

module fbs_queue
#(
    parameter int DATA_W = 8
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              push_valid,
    output logic              push_ready,
    input  logic [DATA_W-1:0] push_data,
    output logic              pop_valid,
    input  logic              pop_ready,
    output logic [DATA_W-1:0] pop_data
);

    logic [DATA_W-1:0]               mem_reg [fbs_pkg::QUEUE_DEPTH];
    logic [fbs_pkg::QUEUE_PTR_W-1:0] wr_ptr_reg;
    logic [fbs_pkg::QUEUE_PTR_W-1:0] wr_ptr_next;
    logic [fbs_pkg::QUEUE_PTR_W-1:0] rd_ptr_reg;
    logic [fbs_pkg::QUEUE_PTR_W-1:0] rd_ptr_next;
    logic [fbs_pkg::QUEUE_CNT_W-1:0] count_reg;
    logic [fbs_pkg::QUEUE_CNT_W-1:0] count_next;
    logic                            push;
    logic                            pop;

    localparam logic [fbs_pkg::QUEUE_PTR_W-1:0] PTR_LAST =
        fbs_pkg::QUEUE_PTR_W'(fbs_pkg::QUEUE_DEPTH - 1);
    localparam logic [fbs_pkg::QUEUE_CNT_W-1:0] CNT_FULL =
        fbs_pkg::QUEUE_CNT_W'(fbs_pkg::QUEUE_DEPTH);

    assign push_ready = (count_reg != CNT_FULL);
    assign pop_valid  = (count_reg != '0);
    assign push       = push_valid && push_ready;
    assign pop        = pop_valid && pop_ready;
    assign pop_data   = mem_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_LAST) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_LAST) ? '0 : rd_ptr_reg + 1'b1;
        end
        unique case ({push, pop})
            2'b10:   count_next = count_reg + 1'b1;
            2'b01:   count_next = count_reg - 1'b1;
            default: count_next = count_reg;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= push_data;
        end
    end

    // fill level tracks the handshakes
    assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_FULL)
    else $error("queue fill level beyond depth");

    assert property (@(posedge clk) disable iff (!rst_n)
        (push && !pop) |=> (count_reg == $past(count_reg) + 1'b1))
    else $error("queue fill level missed a push");

    assert property (@(posedge clk) disable iff (!rst_n)
        (pop && !push) |=> (count_reg == $past(count_reg) - 1'b1))
    else $error("queue fill level missed a pop");

endmodule

// ===== rtl/fbs_back.sv =====
// back end: effect state, expiry and led toggle timing, result register
// depends on fbs_pkg
`timescale 1ns / 1ps

module fbs_back
#(
    parameter int TIME_BITS = 32
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 op_valid,
    output logic                 op_ready,
    input  fbs_pkg::op_t         op,
    input  logic [TIME_BITS-1:0] op_now,
    output logic                 out_valid,
    input  logic                 out_ready,
    output logic                 led_on,
    output logic                 motor_on,
    output logic [10:0]          tone_hz,
    output logic                 busy_res
);

    logic                 running_reg;
    logic                 running_next;
    logic                 soft_mode_reg;
    logic                 soft_mode_next;
    logic [TIME_BITS-1:0] start_time_reg;
    logic [TIME_BITS-1:0] start_time_next;
    logic [11:0]          run_length_reg;
    logic [11:0]          run_length_next;
    logic [TIME_BITS-1:0] toggle_time_reg;
    logic [TIME_BITS-1:0] toggle_time_next;
    logic                 led_level_reg;
    logic                 led_level_next;
    logic                 motor_level_reg;
    logic                 motor_level_next;
    logic [10:0]          tone_value_reg;
    logic [10:0]          tone_value_next;
    logic                 out_valid_reg;
    logic                 out_valid_next;

    logic                 take;
    logic [TIME_BITS-1:0] elapsed;
    logic [TIME_BITS-1:0] since;
    logic [TIME_BITS-1:0] run_len_ext;
    logic [TIME_BITS-1:0] interval_ext;
    logic                 led_flip;

    // the state registers double as the result register
    assign op_ready = !out_valid_reg || out_ready;
    assign take     = op_valid && op_ready;

    assign elapsed      = op_now - start_time_reg;
    assign since        = op_now - toggle_time_reg;
    assign run_len_ext  = {{(TIME_BITS-12){1'b0}}, run_length_reg};
    assign interval_ext = {{(TIME_BITS-8){1'b0}},
                           (soft_mode_reg ? fbs_pkg::IVL_GENTLE_MS : fbs_pkg::IVL_BRISK_MS)};
    assign led_flip     = !led_level_reg;

    always_comb
    begin
        running_next     = running_reg;
        soft_mode_next   = soft_mode_reg;
        start_time_next  = start_time_reg;
        run_length_next  = run_length_reg;
        toggle_time_next = toggle_time_reg;
        led_level_next   = led_level_reg;
        motor_level_next = motor_level_reg;
        tone_value_next  = tone_value_reg;

        if (!op.is_tick)
        begin
            running_next     = 1'b1;
            soft_mode_next   = op.gentle;
            start_time_next  = op_now;
            run_length_next  = op.run_len;
            toggle_time_next = op_now;
            led_level_next   = 1'b0;
            motor_level_next = !op.gentle;
            tone_value_next  = op.gentle ? fbs_pkg::TONE_GENTLE_START
                                         : fbs_pkg::TONE_BRISK_START;
        end
        else if (running_reg)
        begin
            if (elapsed >= run_len_ext)
            begin
                running_next     = 1'b0;
                led_level_next   = 1'b0;
                motor_level_next = 1'b0;
                tone_value_next  = fbs_pkg::TONE_OFF;
            end
            else if (since >= interval_ext)
            begin
                toggle_time_next = op_now;
                led_level_next   = led_flip;
                if (soft_mode_reg)
                begin
                    tone_value_next  = led_flip ? fbs_pkg::TONE_GENTLE_HI
                                                : fbs_pkg::TONE_GENTLE_LO;
                    motor_level_next = 1'b0;
                end
                else
                begin
                    tone_value_next  = led_flip ? fbs_pkg::TONE_BRISK_HI
                                                : fbs_pkg::TONE_BRISK_LO;
                    motor_level_next = led_flip;
                end
            end
        end
    end

    always_comb
    begin
        if (take)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            running_reg     <= 1'b0;
            soft_mode_reg   <= 1'b0;
            start_time_reg  <= '0;
            run_length_reg  <= '0;
            toggle_time_reg <= '0;
            led_level_reg   <= 1'b0;
            motor_level_reg <= 1'b0;
            tone_value_reg  <= fbs_pkg::TONE_OFF;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
            if (take)
            begin
                running_reg     <= running_next;
                soft_mode_reg   <= soft_mode_next;
                start_time_reg  <= start_time_next;
                run_length_reg  <= run_length_next;
                toggle_time_reg <= toggle_time_next;
                led_level_reg   <= led_level_next;
                motor_level_reg <= motor_level_next;
                tone_value_reg  <= tone_value_next;
            end
        end
    end

    assign out_valid = out_valid_reg;
    assign led_on    = led_level_reg;
    assign motor_on  = motor_level_reg;
    assign tone_hz   = tone_value_reg;
    assign busy_res  = running_reg;

    // an idle result is all quiet
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !running_reg) |->
            (!led_level_reg && !motor_level_reg && tone_value_reg == fbs_pkg::TONE_OFF))
    else $error("outputs active while no effect runs");

    // a running effect always sounds one of the pattern tones
    assert property (@(posedge clk) disable iff (!rst_n)
        running_reg |->
            (tone_value_reg == fbs_pkg::TONE_GENTLE_START ||
             tone_value_reg == fbs_pkg::TONE_BRISK_START ||
             tone_value_reg == fbs_pkg::TONE_GENTLE_HI ||
             tone_value_reg == fbs_pkg::TONE_GENTLE_LO ||
             tone_value_reg == fbs_pkg::TONE_BRISK_HI ||
             tone_value_reg == fbs_pkg::TONE_BRISK_LO))
    else $error("running effect with an unexpected tone");

    // gentle pattern never drives the motor
    assert property (@(posedge clk) disable iff (!rst_n)
        (running_reg && soft_mode_reg) |-> !motor_level_reg)
    else $error("motor on during gentle pattern");

endmodule

// ===== rtl/feedback_effect_sequencer.sv =====
// Timed LED, buzzer and vibration motor pattern generator. A start item
// (cmd 0) latches the time, the gentle or brisk mode and an intensity that
// saturates to 1..5; the effect then runs for 400 ms per intensity step plus
// 400 ms (gentle) or 200 ms (brisk). Tick items (cmd 1) carry the current
// millisecond time; elapsed times use wrapping subtraction over the low
// TIME_BITS bits of now_ms. While running, the LED toggles every 180 ms
// (gentle) or 90 ms (brisk), the tone alternates with it and, in brisk mode,
// the motor follows the LED; at expiry every output goes off. Every item
// gives exactly one result item: the drive levels and busy flag after it.
// Rate: one item per clock sustained while out_ready stays high. An accepted
// item is written into the two-entry queue, then taken by the back end, whose
// state registers update and present its result; the queue between the
// classifying front end and the back end lets input and output stall on
// their own.
// depends on fbs_pkg, fbs_front, fbs_queue, fbs_back
`timescale 1ns / 1ps

module feedback_effect_sequencer
#(
    parameter int TIME_BITS = 32
)
(
    input  logic        clk,
    input  logic        rst_n,

    // item input
    input  logic        in_valid,
    output logic        in_ready,
    input  logic        cmd,
    input  logic [31:0] now_ms,
    input  logic        gentle,
    input  logic [3:0]  intensity,

    // result output
    output logic        out_valid,
    input  logic        out_ready,
    output logic        led_on,
    output logic        motor_on,
    output logic [10:0] tone_hz,
    output logic        busy_res
);

    localparam int OP_W    = $bits(fbs_pkg::op_t);
    localparam int ENTRY_W = TIME_BITS + OP_W;

    // classified item from the front end
    fbs_pkg::op_t         front_op;

    // time stamp reduced to the counter width (zero-extended when wider)
    logic [TIME_BITS+31:0] now_wide;
    logic [TIME_BITS-1:0]  now_t;

    // queue ports
    logic [ENTRY_W-1:0]   push_entry;
    logic [ENTRY_W-1:0]   pop_entry;
    logic                 q_valid;
    logic                 q_ready;

    // queue head split back into its parts
    fbs_pkg::op_t         back_op;
    logic [TIME_BITS-1:0] back_now;

    assign now_wide = {{TIME_BITS{1'b0}}, now_ms};
    assign now_t    = now_wide[TIME_BITS-1:0];

    // front end: saturate intensity, work out the run length
    fbs_front u_front
    (
        .cmd       (cmd),
        .gentle    (gentle),
        .intensity (intensity),
        .op        (front_op)
    );

    assign push_entry = {now_t, front_op};

    // decoupling queue; input is taken whenever it has room
    fbs_queue #(
        .DATA_W (ENTRY_W)
    ) u_queue
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (in_valid),
        .push_ready (in_ready),
        .push_data  (push_entry),
        .pop_valid  (q_valid),
        .pop_ready  (q_ready),
        .pop_data   (pop_entry)
    );

    assign back_op  = fbs_pkg::op_t'(pop_entry[OP_W-1:0]);
    assign back_now = pop_entry[ENTRY_W-1:OP_W];

    // back end: effect state machine data path and result register
    fbs_back #(
        .TIME_BITS (TIME_BITS)
    ) u_back
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .op_valid  (q_valid),
        .op_ready  (q_ready),
        .op        (back_op),
        .op_now    (back_now),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .led_on    (led_on),
        .motor_on  (motor_on),
        .tone_hz   (tone_hz),
        .busy_res  (busy_res)
    );

endmodule
